// ----- sv/fisl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisl_pkg
// Shared types, codes and media tables of the floppy image sector locator.
// ----------------------------------------------------------------------------
package fisl_pkg;

  localparam int unsigned DRIVES_DEF = 4;
  localparam int unsigned TRACKS_DEF = 170;

  // operation codes carried by the kind field
  typedef enum logic [3:0] {
    KIND_INSERT    = 4'd0,
    KIND_SET_FLAG  = 4'd1,
    KIND_EJECT     = 4'd2,
    KIND_SEEK      = 4'd3,
    KIND_CUR_ID    = 4'd4,
    KIND_READ_ID   = 4'd5,
    KIND_READ      = 4'd6,
    KIND_READ_DIAG = 4'd7,
    KIND_WRITE     = 4'd8
  } kind_e;

  // media type codes
  localparam logic [3:0] MT_2HD  = 4'd0;
  localparam logic [3:0] MT_2HS  = 4'd1;
  localparam logic [3:0] MT_2HC  = 4'd2;
  localparam logic [3:0] MT_2HDE = 4'd3;
  localparam logic [3:0] MT_2HQ  = 4'd9;

  localparam logic [13:0] BYTES_2HD  = 14'(1024 * 8);
  localparam logic [13:0] BYTES_2HS  = 14'(1024 * 9);
  localparam logic [13:0] BYTES_2HC  = 14'(512 * 15);
  localparam logic [13:0] BYTES_2HDE = 14'(1024 * 9);
  localparam logic [13:0] BYTES_2HQ  = 14'(512 * 18);

  localparam logic [7:0]  LIMIT_2HD    = 8'd153;
  localparam logic [7:0]  LIMIT_OTHER  = 8'd159;
  localparam logic [7:0]  MAX_CYL      = 8'd84;
  localparam logic [7:0]  HEAD_2HDE    = 8'h80;
  localparam logic [20:0] HEADER_BYTES = 21'd256;

  typedef enum logic [2:0] {
    ST_INIT   = 3'd0,
    ST_IDLE   = 3'd1,
    ST_LOOKUP = 3'd2,
    ST_EVAL   = 3'd3,
    ST_CLEAR  = 3'd4
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the input word
    logic lookup;  // read the track flag, form the track product
    logic commit;  // update drive state and the output register
    logic sweep;   // write one zero flag and advance the sweep address
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_req;   // committed word needs the drive's flags cleared
    logic sweep_last;  // sweep address is at its last entry
  } dp_status_t;

  // bytes of one track image; zero for an unknown media type
  function automatic logic [13:0] track_bytes(input logic [3:0] t);
    logic [13:0] b;
    case (t)
      MT_2HD:  b = BYTES_2HD;
      MT_2HS:  b = BYTES_2HS;
      MT_2HC:  b = BYTES_2HC;
      MT_2HDE: b = BYTES_2HDE;
      MT_2HQ:  b = BYTES_2HQ;
      default: b = 14'd0;
    endcase
    return b;
  endfunction

endpackage

// ----- sv/floppy_image_sector_locator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// floppy_image_sector_locator_core
// Sector locator for DRIVES floppy image drives: media insert/eject, track
// flags, seek, and sector ID / image offset lookup for reads and writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command word: kind,
//   drive, track, requested ID and insert settings. Output channel
//   (out_valid_o/out_ready_i) returns exactly one result word per command.
//   A word passes through the capture, the registered read of the track
//   flag memory, and the commit into the output register; in_ready_o is
//   low until the commit, so the next word is taken only after it.
//   Insert, and eject of a loaded drive, add a sweep that zeroes the
//   drive's track flags; in_ready_o is low during it.
//   Reset: all drives unloaded; a sweep zeroes the whole flag memory
//   before the first word is taken.
//   Stall: a result held in the output register does not block the next
//   word from being taken; that word waits in the commit step until the
//   register drains.
// ----------------------------------------------------------------------------
module floppy_image_sector_locator_core #(
  parameter int unsigned DRIVES = fisl_pkg::DRIVES_DEF,
  parameter int unsigned TRACKS = fisl_pkg::TRACKS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  kind_i,
  input  logic [1:0]  drive_i,
  input  logic [7:0]  track_i,
  input  logic [7:0]  id_cyl_i,
  input  logic [7:0]  id_head_i,
  input  logic [7:0]  id_rec_i,
  input  logic [7:0]  id_size_i,
  input  logic [3:0]  media_type_i,
  input  logic        overtrack_i,
  input  logic        flag_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic [7:0]  out_cyl_o,
  output logic [7:0]  out_head_o,
  output logic [4:0]  out_rec_o,
  output logic [1:0]  out_size_o,
  output logic [20:0] image_offset_o,
  output logic [10:0] sector_bytes_o,
  output logic        needs_save_o
);

  localparam int unsigned DEPTH = DRIVES * TRACKS;
  localparam int unsigned AW    = $clog2(DEPTH);

  fisl_pkg::ctrl_cmd_t  cmd;
  fisl_pkg::dp_status_t status;

  logic          ram_we, ram_re, ram_wdata, ram_rdata;
  logic [AW-1:0] ram_waddr, ram_raddr;

  fisl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fisl_datapath #(
    .DRIVES (DRIVES),
    .TRACKS (TRACKS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .kind_i         (kind_i),
    .drive_i        (drive_i),
    .track_i        (track_i),
    .id_cyl_i       (id_cyl_i),
    .id_head_i      (id_head_i),
    .id_rec_i       (id_rec_i),
    .id_size_i      (id_size_i),
    .media_type_i   (media_type_i),
    .overtrack_i    (overtrack_i),
    .flag_value_i   (flag_value_i),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .ok_o           (ok_o),
    .out_cyl_o      (out_cyl_o),
    .out_head_o     (out_head_o),
    .out_rec_o      (out_rec_o),
    .out_size_o     (out_size_o),
    .image_offset_o (image_offset_o),
    .sector_bytes_o (sector_bytes_o),
    .needs_save_o   (needs_save_o)
  );

  fisl_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ----- sv/fisl_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fisl_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/fisl_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisl_ctrl
// Sequencer: flag sweep after reset, word capture, lookup, commit, per-drive
// flag clearing, and the valid bit of the output register.
// ----------------------------------------------------------------------------
module fisl_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  fisl_pkg::dp_status_t   status_i,
  output fisl_pkg::ctrl_cmd_t    cmd_o
);

  fisl_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fisl_pkg::ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      fisl_pkg::ST_INIT: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = fisl_pkg::ST_IDLE;
        end
      end
      fisl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = fisl_pkg::ST_LOOKUP;
        end
      end
      fisl_pkg::ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = fisl_pkg::ST_EVAL;
      end
      fisl_pkg::ST_EVAL: begin
        // hold until the output register is free or drains this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = status_i.clear_req ? fisl_pkg::ST_CLEAR : fisl_pkg::ST_IDLE;
        end
      end
      fisl_pkg::ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = fisl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fisl_pkg::ST_INIT;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/fisl_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisl_datapath
// Per-drive media state, sector ID and image offset arithmetic, output
// payload register and the address side of the track flag memory.
// ----------------------------------------------------------------------------
module fisl_datapath #(
  parameter int unsigned DRIVES = fisl_pkg::DRIVES_DEF,
  parameter int unsigned TRACKS = fisl_pkg::TRACKS_DEF,
  localparam int unsigned DEPTH = DRIVES * TRACKS,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fisl_pkg::ctrl_cmd_t   cmd_i,
  output fisl_pkg::dp_status_t  status_o,
  input  logic [3:0]            kind_i,
  input  logic [1:0]            drive_i,
  input  logic [7:0]            track_i,
  input  logic [7:0]            id_cyl_i,
  input  logic [7:0]            id_head_i,
  input  logic [7:0]            id_rec_i,
  input  logic [7:0]            id_size_i,
  input  logic [3:0]            media_type_i,
  input  logic                  overtrack_i,
  input  logic                  flag_value_i,
  output logic                  ram_we_o,
  output logic [AW-1:0]         ram_waddr_o,
  output logic                  ram_wdata_o,
  output logic                  ram_re_o,
  output logic [AW-1:0]         ram_raddr_o,
  input  logic                  ram_rdata_i,
  output logic                  ok_o,
  output logic [7:0]            out_cyl_o,
  output logic [7:0]            out_head_o,
  output logic [4:0]            out_rec_o,
  output logic [1:0]            out_size_o,
  output logic [20:0]           image_offset_o,
  output logic [10:0]           sector_bytes_o,
  output logic                  needs_save_o
);

  localparam int unsigned DIW       = (DRIVES > 1) ? $clog2(DRIVES) : 1;
  localparam logic [2:0]  DrivesLim = 3'(DRIVES);
  localparam logic [7:0]  TracksLim = 8'(TRACKS);

  typedef struct packed {
    logic [7:0] cyl;
    logic [7:0] head;
    logic [7:0] rec;
    logic [7:0] size;
  } id_t;

  typedef struct packed {
    logic        ok;
    logic [14:0] off;
  } loc_t;

  // type-adjusted ID of track trk, record r
  function automatic id_t make_id(input logic [3:0] t, input logic [7:0] trk,
                                  input logic [7:0] r);
    id_t  id;
    logic first;
    first   = (trk == 8'd0) && (r == 8'd1);
    id.cyl  = {1'b0, trk[7:1]};
    id.head = {7'd0, trk[0]};
    id.rec  = r;
    id.size = 8'd0;
    case (t)
      fisl_pkg::MT_2HD: id.size = 8'd3;
      fisl_pkg::MT_2HS: begin
        if (!first) id.rec = r + 8'd9;
        id.size = 8'd3;
      end
      fisl_pkg::MT_2HDE: begin
        if (!first) id.head = id.head + fisl_pkg::HEAD_2HDE;
        id.size = 8'd3;
      end
      fisl_pkg::MT_2HC, fisl_pkg::MT_2HQ: id.size = 8'd2;
      default: id.size = 8'd0;
    endcase
    return id;
  endfunction

  // position check and in-track byte offset of a sector
  function automatic loc_t locate(input logic [3:0] t, input id_t id);
    loc_t       res;
    logic [7:0] r;
    logic [7:0] h;
    logic [7:0] rm1;
    logic [7:0] maxr;
    logic [7:0] want;
    logic       wide;
    logic       known;
    r     = id.rec;
    h     = id.head;
    maxr  = 8'd0;
    want  = 8'd0;
    wide  = 1'b0;
    known = 1'b1;
    case (t)
      fisl_pkg::MT_2HD: begin
        maxr = 8'd8;  want = 8'd3; wide = 1'b1;
      end
      fisl_pkg::MT_2HS: begin
        if (r > 8'd9) r = r - 8'd9;
        maxr = 8'd9;  want = 8'd3; wide = 1'b1;
      end
      fisl_pkg::MT_2HDE: begin
        h    = {7'd0, h[0]};
        maxr = 8'd9;  want = 8'd3; wide = 1'b1;
      end
      fisl_pkg::MT_2HC: begin
        maxr = 8'd15; want = 8'd2;
      end
      fisl_pkg::MT_2HQ: begin
        maxr = 8'd18; want = 8'd2;
      end
      default: known = 1'b0;
    endcase
    rm1     = r - 8'd1;
    res.ok  = known && (id.cyl <= fisl_pkg::MAX_CYL) && (h <= 8'd1) && (r >= 8'd1)
              && (r <= maxr) && (id.size == want);
    res.off = wide ? {rm1[4:0], 10'd0} : {1'b0, rm1[4:0], 9'd0};
    return res;
  endfunction

  function automatic logic [4:0] mod_small(input logic [5:0] x, input logic [5:0] m);
    logic [5:0] y;
    if (x >= {m[4:0], 1'b0}) begin
      y = x - {m[4:0], 1'b0};
    end else if (x >= m) begin
      y = x - m;
    end else begin
      y = x;
    end
    return y[4:0];
  endfunction

  // sector index after the one at r
  function automatic logic [4:0] next_index(input logic [3:0] t, input logic [7:0] r);
    logic [4:0] r5;
    logic [5:0] x;
    logic [4:0] res;
    r5 = r[4:0];
    if (t == fisl_pkg::MT_2HS && r5 > 5'd8) begin
      r5 = r5 - 5'd9;
    end
    x = {1'b0, r5} + 6'd1;
    case (t)
      fisl_pkg::MT_2HD:  res = {2'd0, x[2:0]};
      fisl_pkg::MT_2HS:  res = mod_small(x, 6'd9);
      fisl_pkg::MT_2HDE: res = mod_small(x, 6'd9);
      fisl_pkg::MT_2HC:  res = mod_small(x, 6'd15);
      fisl_pkg::MT_2HQ:  res = mod_small(x, 6'd18);
      default:           res = r5;
    endcase
    return res;
  endfunction

  // captured word
  logic [3:0] kind_q;
  logic [1:0] drive_q;
  logic [7:0] trk_q, ic_q, ih_q, ir_q, in_q;
  logic [3:0] mt_q;
  logic       ot_q, fv_q;

  // per-drive state
  logic       loaded_q [DRIVES];
  logic [3:0] mkind_q  [DRIVES];
  logic       ovt_q    [DRIVES];
  logic       dirty_q  [DRIVES];
  logic [7:0] cur_q    [DRIVES];
  logic [4:0] sidx_q   [DRIVES];

  logic [20:0]   prod_q;
  logic [AW-1:0] clr_addr_q, clr_end_q;

  logic [DIW-1:0] di;
  logic           drive_ok;
  logic           sel_loaded, sel_ovt, sel_dirty;
  logic [3:0]     sel_kind;
  logic [7:0]     sel_cur;
  logic [4:0]     sel_sidx;
  logic [AW-1:0]  base;
  logic [7:0]     lin;
  logic [21:0]    prod_full;
  logic [7:0]     lim;
  logic           trk_ok, trk_in_range, on_track;
  id_t            id_cur, id_seek, id_req, loc_id;
  loc_t           loc;
  logic [20:0]    pos;

  logic        r_ok, r_save;
  id_t         r_id;
  logic [20:0] r_pos;
  logic [10:0] r_bytes;
  logic        nx_loaded, nx_ovt, nx_dirty;
  logic [3:0]  nx_kind;
  logic [7:0]  nx_cur;
  logic [4:0]  nx_sidx;
  logic        flag_we, clear_req;

  assign di         = drive_q[DIW-1:0];
  assign drive_ok   = {1'b0, drive_q} < DrivesLim;
  assign sel_loaded = loaded_q[di];
  assign sel_kind   = mkind_q[di];
  assign sel_ovt    = ovt_q[di];
  assign sel_dirty  = dirty_q[di];
  assign sel_cur    = cur_q[di];
  assign sel_sidx   = sidx_q[di];
  assign base       = AW'(di) * AW'(TRACKS);

  // track number for the offset product; a request off cylinder 0..84, or off head 0..1 for
  // media other than 2HDE, fails the position check, so its low bits are enough
  assign lin       = (kind_q == fisl_pkg::KIND_READ_DIAG) ? sel_cur : {ic_q[6:0], ih_q[0]};
  assign prod_full = 22'(fisl_pkg::track_bytes(sel_kind)) * 22'(lin);

  assign lim          = (sel_kind == fisl_pkg::MT_2HD) ? fisl_pkg::LIMIT_2HD
                                                       : fisl_pkg::LIMIT_OTHER;
  assign trk_in_range = trk_q < TracksLim;
  assign trk_ok       = (fisl_pkg::track_bytes(sel_kind) != 14'd0) && (sel_cur < TracksLim)
                        && !((sel_cur > lim) && !sel_ovt) && ram_rdata_i;
  assign on_track     = ({ic_q, 1'b0} + {8'd0, ih_q[0]}) == {1'b0, sel_cur};

  assign id_cur  = make_id(sel_kind, sel_cur, {3'd0, sel_sidx} + 8'd1);
  assign id_seek = make_id(sel_kind, trk_q,
                           (sel_cur != trk_q) ? 8'd1 : ({3'd0, sel_sidx} + 8'd1));
  assign id_req  = '{cyl: ic_q, head: ih_q, rec: ir_q, size: in_q};
  assign loc_id  = (kind_q == fisl_pkg::KIND_READ_DIAG) ? id_cur : id_req;
  assign loc     = locate(sel_kind, loc_id);
  assign pos     = prod_q + 21'(loc.off) + fisl_pkg::HEADER_BYTES;

  always_comb begin
    r_ok      = 1'b0;
    r_save    = 1'b0;
    r_id      = '0;
    r_pos     = '0;
    r_bytes   = '0;
    nx_loaded = sel_loaded;
    nx_kind   = sel_kind;
    nx_ovt    = sel_ovt;
    nx_dirty  = sel_dirty;
    nx_cur    = sel_cur;
    nx_sidx   = sel_sidx;
    flag_we   = 1'b0;
    clear_req = 1'b0;
    if (drive_ok) begin
      case (kind_q)
        fisl_pkg::KIND_INSERT: begin
          clear_req = 1'b1;
          nx_dirty  = 1'b0;
          if (fisl_pkg::track_bytes(mt_q) != 14'd0) begin
            nx_loaded = 1'b1;
            nx_kind   = mt_q;
            nx_ovt    = ot_q;
            r_ok      = 1'b1;
          end else begin
            nx_loaded = 1'b0;
          end
        end
        fisl_pkg::KIND_SET_FLAG: begin
          if (sel_loaded && trk_in_range) begin
            flag_we = 1'b1;
            r_ok    = 1'b1;
          end
        end
        fisl_pkg::KIND_EJECT: begin
          if (sel_loaded) begin
            r_save    = sel_dirty;
            r_ok      = 1'b1;
            nx_loaded = 1'b0;
            nx_dirty  = 1'b0;
            clear_req = 1'b1;
          end
        end
        fisl_pkg::KIND_SEEK: begin
          if (sel_loaded && trk_in_range) begin
            if (sel_cur != trk_q) nx_sidx = 5'd0;
            r_id   = id_seek;
            nx_cur = trk_q;
            r_ok   = 1'b1;
          end
        end
        fisl_pkg::KIND_CUR_ID, fisl_pkg::KIND_READ_ID: begin
          if (sel_loaded && trk_ok) begin
            r_id = id_cur;
            if (kind_q == fisl_pkg::KIND_READ_ID) begin
              nx_sidx = next_index(sel_kind, {3'd0, sel_sidx});
            end
            r_ok = 1'b1;
          end
        end
        fisl_pkg::KIND_READ_DIAG: begin
          if (sel_loaded && trk_ok && loc.ok) begin
            r_id    = id_cur;
            r_pos   = pos;
            r_bytes = (id_cur.size == 8'd2) ? 11'd512 : 11'd1024;
            nx_sidx = next_index(sel_kind, {3'd0, sel_sidx});
            r_ok    = 1'b1;
          end
        end
        fisl_pkg::KIND_READ, fisl_pkg::KIND_WRITE: begin
          if (sel_loaded && on_track && trk_ok && loc.ok) begin
            r_id    = id_req;
            r_pos   = pos;
            r_bytes = (in_q == 8'd2) ? 11'd512 : 11'd1024;
            nx_sidx = next_index(sel_kind, ir_q - 8'd1);
            if (kind_q == fisl_pkg::KIND_WRITE) nx_dirty = 1'b1;
            r_ok    = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      drive_q <= drive_i;
      trk_q   <= track_i;
      ic_q    <= id_cyl_i;
      ih_q    <= id_head_i;
      ir_q    <= id_rec_i;
      in_q    <= id_size_i;
      mt_q    <= media_type_i;
      ot_q    <= overtrack_i;
      fv_q    <= flag_value_i;
    end
    if (cmd_i.lookup) begin
      prod_q <= prod_full[20:0];
    end
    if (cmd_i.commit) begin
      ok_o           <= r_ok;
      out_cyl_o      <= r_id.cyl;
      out_head_o     <= r_id.head;
      out_rec_o      <= r_id.rec[4:0];
      out_size_o     <= r_id.size[1:0];
      image_offset_o <= r_pos;
      sector_bytes_o <= r_bytes;
      needs_save_o   <= r_save;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DRIVES; i++) begin
        loaded_q[i] <= 1'b0;
        mkind_q[i]  <= 4'd0;
        ovt_q[i]    <= 1'b0;
        dirty_q[i]  <= 1'b0;
        cur_q[i]    <= 8'd0;
        sidx_q[i]   <= 5'd0;
      end
    end else if (cmd_i.commit && drive_ok) begin
      for (int i = 0; i < DRIVES; i++) begin
        if (di == DIW'(i)) begin
          loaded_q[i] <= nx_loaded;
          mkind_q[i]  <= nx_kind;
          ovt_q[i]    <= nx_ovt;
          dirty_q[i]  <= nx_dirty;
          cur_q[i]    <= nx_cur;
          sidx_q[i]   <= nx_sidx;
        end
      end
    end
  end

  // sweep window: whole store after reset, one drive's tracks afterwards
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_end_q  <= AW'(DEPTH - 1);
    end else if (cmd_i.commit && clear_req) begin
      clr_addr_q <= base;
      clr_end_q  <= base + AW'(TRACKS - 1);
    end else if (cmd_i.sweep) begin
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  assign ram_we_o    = cmd_i.sweep || (cmd_i.commit && flag_we);
  assign ram_waddr_o = cmd_i.sweep ? clr_addr_q : (base + AW'(trk_q));
  assign ram_wdata_o = cmd_i.sweep ? 1'b0 : fv_q;
  assign ram_re_o    = cmd_i.lookup;
  assign ram_raddr_o = base + AW'(sel_cur);

  assign status_o.clear_req  = clear_req;
  assign status_o.sweep_last = (clr_addr_q == clr_end_q);

endmodule

// ----- sv/fisl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisl_checker
// Port-level checks of the sector locator, bound to the top level.
// ----------------------------------------------------------------------------
module fisl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        ok_o,
  input logic [7:0]  out_cyl_o,
  input logic [7:0]  out_head_o,
  input logic [4:0]  out_rec_o,
  input logic [1:0]  out_size_o,
  input logic [20:0] image_offset_o,
  input logic [10:0] sector_bytes_o,
  input logic        needs_save_o
);

  // hold a stalled result word (out_size_o is not checked)
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ok_o) && $stable(out_cyl_o)
      && $stable(out_head_o) && $stable(out_rec_o) && $stable(image_offset_o)
      && $stable(sector_bytes_o) && $stable(needs_save_o))
    else $error("result word changed while stalled");

  // one word in flight: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after an accept");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> out_cyl_o == 8'd0 && out_head_o == 8'd0 && out_rec_o == 5'd0
      && out_size_o == 2'd0 && image_offset_o == 21'd0 && sector_bytes_o == 11'd0
      && !needs_save_o)
    else $error("failed word carries data");

  a_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sector_bytes_o != 11'd0 |-> ok_o && !needs_save_o
      && (sector_bytes_o == 11'd512 || sector_bytes_o == 11'd1024)
      && image_offset_o >= 21'd256)
    else $error("bad transfer word");

  a_save: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && needs_save_o |-> ok_o && out_cyl_o == 8'd0 && out_rec_o == 5'd0
      && image_offset_o == 21'd0 && sector_bytes_o == 11'd0)
    else $error("save flag on a non-eject word");

endmodule

bind floppy_image_sector_locator_core fisl_checker u_fisl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .ok_o           (ok_o),
  .out_cyl_o      (out_cyl_o),
  .out_head_o     (out_head_o),
  .out_rec_o      (out_rec_o),
  .out_size_o     (out_size_o),
  .image_offset_o (image_offset_o),
  .sector_bytes_o (sector_bytes_o),
  .needs_save_o   (needs_save_o)
);
